@@ rtl/core/blfc_pkg.sv @@
package blfc_pkg;

    localparam int SAMPLE_W = 24;
    localparam int OP_W     = 2;
    localparam int INDEX_W  = 12;
    localparam int COUNT_W  = 13;
    localparam int PROD_W   = 2 * SAMPLE_W;

    // Q1.23 limits
    localparam int Q_MAX = 8388607;
    localparam int Q_MIN = -8388608;

    // operation codes
    localparam logic [OP_W-1:0] OP_SAMPLE = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD   = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]            operation;
        logic signed [SAMPLE_W-1:0] sample;
        logic [INDEX_W-1:0]         tap_index;
        logic signed [SAMPLE_W-1:0] tap_value;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] output_sample;
        logic                       clipped;
    } out_item_t;

    // per-cell strobes from the sequencer
    typedef struct packed {
        logic hist_rd;
        logic hist_wr;
        logic hist_wzero;
        logic coef_rd;
        logic coef_wr;
        logic mac_go;
        logic mac_first;
        logic mac_use;
    } cell_ctl_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOAD,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_MAC,
        ST_DRAIN,
        ST_FINISH
    } state_t;

endpackage

@@ rtl/core/blfc_ram.sv @@
module blfc_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/blfc_cell.sv @@
module blfc_cell #(
    parameter int DEPTH = 1024,
    parameter int ACC_W = 61
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  blfc_pkg::cell_ctl_t                 ctl,
    input  logic [$clog2(DEPTH)-1:0]            hist_raddr,
    input  logic [$clog2(DEPTH)-1:0]            hist_waddr,
    input  logic [$clog2(DEPTH)-1:0]            coef_raddr,
    input  logic [$clog2(DEPTH)-1:0]            coef_waddr,
    input  logic signed [blfc_pkg::SAMPLE_W-1:0] coef_wdata,
    input  logic signed [blfc_pkg::SAMPLE_W-1:0] hand_in,
    output logic signed [blfc_pkg::SAMPLE_W-1:0] hand_out,
    input  logic signed [ACC_W-1:0]             sum_in,
    output logic signed [ACC_W-1:0]             sum_out
);

    logic [blfc_pkg::SAMPLE_W-1:0]        hist_wdata;
    logic [blfc_pkg::SAMPLE_W-1:0]        hist_rdata;
    logic [blfc_pkg::SAMPLE_W-1:0]        coef_rdata;
    logic signed [blfc_pkg::PROD_W-1:0]   prod_next;
    logic signed [blfc_pkg::PROD_W-1:0]   prod_reg;
    logic signed [ACC_W-1:0]              acc_reg;
    logic signed [ACC_W-1:0]              sum_reg;
    logic                                 go1_reg;
    logic                                 first1_reg;
    logic                                 use1_reg;
    logic                                 go2_reg;
    logic                                 first2_reg;

    // zero on a clearing sweep, otherwise take the neighbour's oldest sample
    assign hist_wdata = ctl.hist_wzero ? '0 : hand_in;

    blfc_ram #(
        .WIDTH(blfc_pkg::SAMPLE_W),
        .DEPTH(DEPTH)
    ) u_hist (
        .clk  (clk),
        .we   (ctl.hist_wr),
        .waddr(hist_waddr),
        .wdata(hist_wdata),
        .re   (ctl.hist_rd),
        .raddr(hist_raddr),
        .rdata(hist_rdata)
    );

    blfc_ram #(
        .WIDTH(blfc_pkg::SAMPLE_W),
        .DEPTH(DEPTH)
    ) u_coef (
        .clk  (clk),
        .we   (ctl.coef_wr),
        .waddr(coef_waddr),
        .wdata(coef_wdata),
        .re   (ctl.coef_rd),
        .raddr(coef_raddr),
        .rdata(coef_rdata)
    );

    assign hand_out  = $signed(hist_rdata);
    assign prod_next = $signed(coef_rdata) * $signed(hist_rdata);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            go1_reg    <= 1'b0;
            first1_reg <= 1'b0;
            use1_reg   <= 1'b0;
            go2_reg    <= 1'b0;
            first2_reg <= 1'b0;
        end
        else
        begin
            go1_reg    <= ctl.mac_go;
            first1_reg <= ctl.mac_first;
            use1_reg   <= ctl.mac_use;
            go2_reg    <= go1_reg;
            first2_reg <= first1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        // drop taps beyond the active count
        prod_reg <= use1_reg ? prod_next : '0;
        if (go2_reg)
        begin
            acc_reg <= first2_reg ? ACC_W'(prod_reg) : acc_reg + ACC_W'(prod_reg);
        end
        sum_reg <= acc_reg + sum_in;
    end

    assign sum_out = sum_reg;

endmodule

@@ rtl/core/block_latency_fir_convolver_core.sv @@
// Long FIR filter with one block of latency (direct-form equivalent of
// uniformly partitioned overlap-save), Q1.23 in and out.
// Input channel in_valid/in_stall/in_item: operation 0 is an audio sample
// and gives one result, 1 loads one tap, 2 clears the sample history.
// Output channel out_valid/out_stall/out_item: filtered sample, rounded half
// up and saturated, with clipped set when saturation occurred.
// tap_count_we/tap_count_wdata set the number of taps in use; zero bypasses
// the filter and returns the input sample (still kept in the history).
// Samples pass through a BLOCK_LEN delay line and then a row of CELL_COUNT
// cells, each owning ceil(MAX_TAPS/CELL_COUNT) taps and as many samples; all
// cells multiply-accumulate in parallel and pass partial sums down the row.
// In a sample item each cell reads one coefficient per cycle, L being the
// taps per cell; a bypassed sample skips the MAC and drain states, and a
// load steps along the cells to the one that holds its tap.
// After reset, and after a clear item, a sweep over max(L, BLOCK_LEN) addresses
// zeroes the memories (taps only after reset) while in_stall stays high.
// One result is held in an output register; the next item is taken while it
// waits, but a new result is held back until the old one has transferred.
module block_latency_fir_convolver_core #(
    parameter int BLOCK_LEN  = 64,
    parameter int MAX_TAPS   = 4096,
    parameter int CELL_COUNT = 4
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  blfc_pkg::in_item_t               in_item,
    output logic                             out_valid,
    input  logic                             out_stall,
    output blfc_pkg::out_item_t              out_item,
    input  logic                             tap_count_we,
    input  logic [blfc_pkg::COUNT_W-1:0]     tap_count_wdata
);

    // taps and samples held by each cell
    localparam int L       = (MAX_TAPS + CELL_COUNT - 1) / CELL_COUNT;
    localparam int AW      = $clog2(L);
    localparam int DAW     = $clog2(BLOCK_LEN);
    localparam int CLR_LEN = (L > BLOCK_LEN) ? L : BLOCK_LEN;
    localparam int CLW     = $clog2(CLR_LEN);
    localparam int CW      = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
    localparam int DRW     = $clog2(CELL_COUNT + 3);
    localparam int TAP_W   = $clog2(MAX_TAPS + 1);
    localparam int ACC_W   = 49 + $clog2(MAX_TAPS);
    localparam int SW      = blfc_pkg::SAMPLE_W;
    localparam logic signed [ACC_W:0] ROUND_HALF = (ACC_W + 1)'(4194304);

    blfc_pkg::state_t            state_reg;
    blfc_pkg::state_t            state_next;
    blfc_pkg::in_item_t          item_reg;
    blfc_pkg::out_item_t         out_reg;
    blfc_pkg::out_item_t         result;
    blfc_pkg::cell_ctl_t         base_ctl;
    blfc_pkg::cell_ctl_t         cell_ctl [CELL_COUNT];

    logic                        out_valid_reg;
    logic                        out_free;
    logic                        in_accept;
    logic [blfc_pkg::COUNT_W-1:0] tap_count_reg;
    logic [TAP_W-1:0]            taps_eff;
    logic                        bypass_reg;
    logic                        clr_coef_reg;
    logic [CLW-1:0]              clr_cnt_reg;
    logic [AW-1:0]               hp_reg;
    logic [AW-1:0]               ra_reg;
    logic [AW-1:0]               j_reg;
    logic [DAW-1:0]              dp_reg;
    logic [DRW-1:0]              drain_reg;
    logic [blfc_pkg::INDEX_W-1:0] rem_reg;
    logic [CW-1:0]               load_cell_reg;
    logic                        rem_fits;
    logic                        clr_in_cells;
    logic                        clr_in_delay;
    logic                        load_wr;
    logic [CELL_COUNT-1:0]       coef_sel;

    logic [AW-1:0]               hist_raddr;
    logic [AW-1:0]               hist_waddr;
    logic [AW-1:0]               coef_raddr;
    logic [AW-1:0]               coef_waddr;
    logic signed [SW-1:0]        coef_wdata;
    logic                        dly_we;
    logic                        dly_re;
    logic [DAW-1:0]              dly_waddr;
    logic [DAW-1:0]              dly_raddr;
    logic [SW-1:0]               dly_wdata;
    logic [SW-1:0]               dly_rdata;

    logic signed [SW-1:0]        hand [CELL_COUNT + 1];
    logic signed [ACC_W-1:0]     sum_w [CELL_COUNT + 1];
    logic signed [ACC_W:0]       rnd_sum;
    logic signed [ACC_W:0]       rnd_q;

    // handshakes
    assign in_stall  = (state_reg != blfc_pkg::ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    // a count above the store size acts as the store size
    assign taps_eff = (32'(tap_count_reg) > 32'(MAX_TAPS)) ? TAP_W'(MAX_TAPS)
                                                           : TAP_W'(tap_count_reg);

    assign rem_fits     = 32'(rem_reg) < 32'(L);
    assign clr_in_cells = 32'(clr_cnt_reg) < 32'(L);
    assign clr_in_delay = 32'(clr_cnt_reg) < 32'(BLOCK_LEN);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            blfc_pkg::ST_CLEAR:
            begin
                if (clr_cnt_reg == CLW'(CLR_LEN - 1))
                begin
                    state_next = blfc_pkg::ST_IDLE;
                end
            end
            blfc_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (in_item.operation)
                        blfc_pkg::OP_SAMPLE: state_next = blfc_pkg::ST_SHIFT_RD;
                        blfc_pkg::OP_LOAD:
                        begin
                            if (32'(in_item.tap_index) < 32'(MAX_TAPS))
                            begin
                                state_next = blfc_pkg::ST_LOAD;
                            end
                        end
                        blfc_pkg::OP_CLEAR:  state_next = blfc_pkg::ST_CLEAR;
                        default:             state_next = blfc_pkg::ST_IDLE;
                    endcase
                end
            end
            blfc_pkg::ST_LOAD:
            begin
                if (rem_fits)
                begin
                    state_next = blfc_pkg::ST_IDLE;
                end
            end
            blfc_pkg::ST_SHIFT_RD: state_next = blfc_pkg::ST_SHIFT_WR;
            blfc_pkg::ST_SHIFT_WR:
            begin
                state_next = (taps_eff == '0) ? blfc_pkg::ST_FINISH : blfc_pkg::ST_MAC;
            end
            blfc_pkg::ST_MAC:
            begin
                if (j_reg == AW'(L - 1))
                begin
                    state_next = blfc_pkg::ST_DRAIN;
                end
            end
            blfc_pkg::ST_DRAIN:
            begin
                // last cell's partial sum is complete after the memory read, product,
                // accumulate and row stages
                if (drain_reg == DRW'(CELL_COUNT + 2))
                begin
                    state_next = blfc_pkg::ST_FINISH;
                end
            end
            blfc_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = blfc_pkg::ST_IDLE;
                end
            end
            default: state_next = blfc_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        base_ctl   = '0;
        load_wr    = 1'b0;
        hist_raddr = hp_reg;
        hist_waddr = hp_reg;
        coef_raddr = j_reg;
        coef_waddr = AW'(clr_cnt_reg);
        coef_wdata = '0;
        dly_we     = 1'b0;
        dly_re     = 1'b0;
        dly_waddr  = dp_reg;
        dly_raddr  = dp_reg;
        dly_wdata  = '0;
        case (state_reg)
            blfc_pkg::ST_CLEAR:
            begin
                base_ctl.hist_wr    = clr_in_cells;
                base_ctl.hist_wzero = 1'b1;
                base_ctl.coef_wr    = clr_in_cells && clr_coef_reg;
                hist_waddr          = AW'(clr_cnt_reg);
                dly_we              = clr_in_delay;
                dly_waddr           = DAW'(clr_cnt_reg);
            end
            blfc_pkg::ST_LOAD:
            begin
                load_wr    = rem_fits;
                coef_waddr = AW'(rem_reg);
                coef_wdata = item_reg.tap_value;
            end
            blfc_pkg::ST_SHIFT_RD:
            begin
                base_ctl.hist_rd = 1'b1;
                dly_re           = 1'b1;
            end
            blfc_pkg::ST_SHIFT_WR:
            begin
                // newest sample into the delay line, every cell takes the
                // oldest sample of the one before it
                base_ctl.hist_wr = 1'b1;
                dly_we           = 1'b1;
                dly_wdata        = item_reg.sample;
            end
            blfc_pkg::ST_MAC:
            begin
                base_ctl.hist_rd   = 1'b1;
                base_ctl.coef_rd   = 1'b1;
                base_ctl.mac_go    = 1'b1;
                base_ctl.mac_first = (j_reg == '0);
                hist_raddr         = ra_reg;
            end
            default:
            begin
                base_ctl = '0;
            end
        endcase
    end

    // per-cell strobes: tap select on loads, tap-count mask on MACs
    for (genvar i = 0; i < CELL_COUNT; i++)
    begin : g_ctl
        localparam int BASE = i * L;

        assign coef_sel[i] = load_wr && (load_cell_reg == CW'(i));

        always_comb
        begin
            cell_ctl[i]         = base_ctl;
            cell_ctl[i].coef_wr = base_ctl.coef_wr || coef_sel[i];
            cell_ctl[i].mac_use = base_ctl.mac_go
                                  && ((32'(BASE) + 32'(j_reg)) < 32'(taps_eff));
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= blfc_pkg::ST_CLEAR;
            tap_count_reg <= '0;
            clr_cnt_reg   <= '0;
            clr_coef_reg  <= 1'b1;
            hp_reg        <= '0;
            dp_reg        <= '0;
            ra_reg        <= '0;
            j_reg         <= '0;
            drain_reg     <= '0;
            rem_reg       <= '0;
            load_cell_reg <= '0;
            bypass_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (tap_count_we)
            begin
                tap_count_reg <= tap_count_wdata;
            end
            case (state_reg)
                blfc_pkg::ST_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (state_next == blfc_pkg::ST_IDLE)
                    begin
                        clr_coef_reg <= 1'b0;
                    end
                end
                blfc_pkg::ST_IDLE:
                begin
                    if (in_accept)
                    begin
                        j_reg         <= '0;
                        drain_reg     <= '0;
                        rem_reg       <= in_item.tap_index;
                        load_cell_reg <= '0;
                        if (in_item.operation == blfc_pkg::OP_CLEAR)
                        begin
                            // taps are kept, history and positions restart
                            clr_cnt_reg <= '0;
                            hp_reg      <= '0;
                            dp_reg      <= '0;
                        end
                    end
                end
                blfc_pkg::ST_LOAD:
                begin
                    if (!rem_fits)
                    begin
                        rem_reg       <= rem_reg - blfc_pkg::INDEX_W'(L);
                        load_cell_reg <= load_cell_reg + 1'b1;
                    end
                end
                blfc_pkg::ST_SHIFT_WR:
                begin
                    bypass_reg <= (taps_eff == '0);
                    ra_reg     <= hp_reg;
                    hp_reg     <= (hp_reg == AW'(L - 1)) ? '0 : hp_reg + 1'b1;
                    dp_reg     <= (dp_reg == DAW'(BLOCK_LEN - 1)) ? '0 : dp_reg + 1'b1;
                end
                blfc_pkg::ST_MAC:
                begin
                    j_reg  <= j_reg + 1'b1;
                    ra_reg <= (ra_reg == '0) ? AW'(L - 1) : ra_reg - 1'b1;
                end
                blfc_pkg::ST_DRAIN:
                begin
                    drain_reg <= drain_reg + 1'b1;
                end
                default:
                begin
                    bypass_reg <= bypass_reg;
                end
            endcase
            if ((state_reg == blfc_pkg::ST_FINISH) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            item_reg <= in_item;
        end
        if ((state_reg == blfc_pkg::ST_FINISH) && out_free)
        begin
            out_reg <= result;
        end
    end

    // delay line of BLOCK_LEN samples ahead of the cell row
    blfc_ram #(
        .WIDTH(SW),
        .DEPTH(BLOCK_LEN)
    ) u_delay (
        .clk  (clk),
        .we   (dly_we),
        .waddr(dly_waddr),
        .wdata(dly_wdata),
        .re   (dly_re),
        .raddr(dly_raddr),
        .rdata(dly_rdata)
    );

    assign hand[0]  = $signed(dly_rdata);
    assign sum_w[0] = '0;

    for (genvar i = 0; i < CELL_COUNT; i++)
    begin : g_cell
        blfc_cell #(
            .DEPTH(L),
            .ACC_W(ACC_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (cell_ctl[i]),
            .hist_raddr(hist_raddr),
            .hist_waddr(hist_waddr),
            .coef_raddr(coef_raddr),
            .coef_waddr(coef_waddr),
            .coef_wdata(coef_wdata),
            .hand_in   (hand[i]),
            .hand_out  (hand[i + 1]),
            .sum_in    (sum_w[i]),
            .sum_out   (sum_w[i + 1])
        );
    end

    // round half up to Q1.23, then saturate
    assign rnd_sum = (ACC_W + 1)'(sum_w[CELL_COUNT]) + ROUND_HALF;
    assign rnd_q   = rnd_sum >>> 23;

    always_comb
    begin
        result.output_sample = SW'(rnd_q);
        result.clipped       = 1'b0;
        if (bypass_reg)
        begin
            result.output_sample = item_reg.sample;
        end
        else if (rnd_q > (ACC_W + 1)'(blfc_pkg::Q_MAX))
        begin
            result.output_sample = SW'(blfc_pkg::Q_MAX);
            result.clipped       = 1'b1;
        end
        else if (rnd_q < (ACC_W + 1)'(blfc_pkg::Q_MIN))
        begin
            result.output_sample = SW'(blfc_pkg::Q_MIN);
            result.clipped       = 1'b1;
        end
    end

    // a clipped result carries one of the two rail values
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_item.clipped) |->
            (out_item.output_sample == SW'(blfc_pkg::Q_MAX))
            || (out_item.output_sample == SW'(blfc_pkg::Q_MIN)))
        else $error("clipped result not at a rail");

    // a tap load never walks past the last cell
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == blfc_pkg::ST_LOAD) |-> (32'(load_cell_reg) < 32'(CELL_COUNT)))
        else $error("tap load beyond the cell row");

    // at most one cell takes a loaded tap
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != blfc_pkg::ST_CLEAR) |-> $onehot0(coef_sel))
        else $error("tap written to several cells");

    // the ring positions stay inside the cell stores and the delay line
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> (32'(hp_reg) < 32'(L)) && (32'(dp_reg) < 32'(BLOCK_LEN)))
        else $error("history position out of range");

endmodule

@@ tb/tb_block_latency_fir_convolver_core.sv @@
module tb_block_latency_fir_convolver_core;

    // Geometry of the block at its default parameters
    localparam int BLOCK_LEN  = 64;
    localparam int MAX_TAPS   = 4096;
    localparam int HIST_DEPTH = MAX_TAPS + BLOCK_LEN;

    // The package names no code for the fourth operation; the block ignores it
    localparam logic [blfc_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

    // Covers any load or clear still at work once the last result has come
    localparam int SETTLE_CYCLES = 1200;
    // Receiver hold-off, long enough to back the block up into its input
    localparam int HOLD_CYCLES   = 3000;
    // Watchdog limit, well above the slowest correct run
    localparam longint RUN_LIMIT = 64'd50_000_000;

    logic                           clk             = 1'b0;
    logic                           rst_n           = 1'b0;
    logic                           in_valid        = 1'b0;
    logic                           in_stall;
    blfc_pkg::in_item_t             in_item         = '0;
    logic                           out_valid;
    logic                           out_stall       = 1'b0;
    blfc_pkg::out_item_t            out_item;
    logic                           tap_count_we    = 1'b0;
    logic [blfc_pkg::COUNT_W-1:0]   tap_count_wdata = '0;

    // Items waiting to be offered, and filtered samples still owed by the block
    blfc_pkg::in_item_t             item_backlog[$];
    blfc_pkg::out_item_t            filtered_due[$];

    // Shadow of the filter state, advanced on every accepted transfer
    logic signed [blfc_pkg::SAMPLE_W-1:0] coef_mem[MAX_TAPS];
    logic signed [blfc_pkg::SAMPLE_W-1:0] hist_mem[HIST_DEPTH];
    int unsigned                          hist_pos    = 0;
    logic [blfc_pkg::COUNT_W-1:0]         tap_setting = '0;

    // Idling knobs, as percentages of cycles
    int                   send_idle_pct  = 0;
    int                   recv_stall_pct = 0;

    // Hold-off request: toggle hold_kick and the counter below reloads
    logic                 hold_kick = 1'b0;
    logic                 hold_seen = 1'b0;
    int                   hold_left = 0;

    int                   fail_count = 0;

    block_latency_fir_convolver_core dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .in_item         (in_item),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .out_item        (out_item),
        .tap_count_we    (tap_count_we),
        .tap_count_wdata (tap_count_wdata)
    );

    always #5 clk = ~clk;

    // Advance the shadow filter by one accepted item. Samples enter the ring
    // first, then the sum walks back from the slot one block earlier.
    function automatic void predict_filter(blfc_pkg::in_item_t it);
        int unsigned         pos;
        int unsigned         rd;
        int unsigned         taps;
        int unsigned         k;
        longint              acc;
        longint              y;
        blfc_pkg::out_item_t res;
        case (it.operation)
            blfc_pkg::OP_LOAD:
                coef_mem[it.tap_index] = it.tap_value;
            blfc_pkg::OP_CLEAR:
            begin
                foreach (hist_mem[i])
                    hist_mem[i] = '0;
                hist_pos = 0;
            end
            blfc_pkg::OP_SAMPLE:
            begin
                pos = hist_pos;
                hist_mem[pos] = it.sample;
                hist_pos = (pos + 1 == HIST_DEPTH) ? 0 : pos + 1;
                taps = (32'(tap_setting) > MAX_TAPS) ? MAX_TAPS : 32'(tap_setting);
                if (taps == 0)
                begin
                    // bypass: the sample comes straight back, never clipped
                    res.output_sample = it.sample;
                    res.clipped = 1'b0;
                end
                else
                begin
                    rd = (pos + HIST_DEPTH - BLOCK_LEN) % HIST_DEPTH;
                    acc = 0;
                    for (k = 0; k < taps; k++)
                    begin
                        acc += longint'(coef_mem[k]) * longint'(hist_mem[rd]);
                        rd = (rd == 0) ? HIST_DEPTH - 1 : rd - 1;
                    end
                    // round half up from Q2.46 to Q1.23, then saturate
                    y = (acc + 64'sd4194304) >>> 23;
                    res.clipped = 1'b0;
                    if (y > blfc_pkg::Q_MAX)
                    begin
                        y = blfc_pkg::Q_MAX;
                        res.clipped = 1'b1;
                    end
                    else if (y < blfc_pkg::Q_MIN)
                    begin
                        y = blfc_pkg::Q_MIN;
                        res.clipped = 1'b1;
                    end
                    res.output_sample = y[blfc_pkg::SAMPLE_W-1:0];
                end
                filtered_due.push_back(res);
            end
            default: ;
        endcase
    endfunction

    // Driver: record each transfer in the shadow filter, then hold the
    // payload while stalled or offer the next item unless idling this cycle.
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && !in_stall)
                predict_filter(in_item);
            if (!in_valid || !in_stall)
            begin
                if (item_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    in_item  <= item_backlog.pop_front();
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Hold-off counter in its own process; reload on each toggle of the kick
    always @(posedge clk)
    begin
        if (hold_kick != hold_seen)
        begin
            hold_seen <= hold_kick;
            hold_left <= HOLD_CYCLES;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // Monitor: compare each transfer on the result side with the oldest
    // filtered sample owed, and drive the receiver stall.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (filtered_due.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result: sample %0d clipped %0b",
                                 out_item.output_sample, out_item.clipped);
                end
                else
                begin
                    blfc_pkg::out_item_t want;
                    want = filtered_due.pop_front();
                    if (out_item.output_sample !== want.output_sample
                        || out_item.clipped !== want.clipped)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("result mismatch: expected %0d/%0b, got %0d/%0b",
                                     want.output_sample, want.clipped,
                                     out_item.output_sample, out_item.clipped);
                    end
                end
            end
            out_stall <= (hold_left != 0) || ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // Q1.23 value biased to the edges: extremes, small, powers of two, any
    function automatic logic signed [blfc_pkg::SAMPLE_W-1:0] random_q();
        int p;
        p = 1 << $urandom_range(0, 22);
        case ($urandom_range(0, 9))
            0:       return blfc_pkg::SAMPLE_W'(blfc_pkg::Q_MAX);
            1:       return blfc_pkg::SAMPLE_W'(blfc_pkg::Q_MIN);
            2, 3:    return blfc_pkg::SAMPLE_W'($urandom_range(0, 8191) - 4096);
            4:       return blfc_pkg::SAMPLE_W'($urandom_range(0, 1) ? -p : p);
            default: return blfc_pkg::SAMPLE_W'($urandom());
        endcase
    endfunction

    // Mostly samples and tap loads aimed at the taps in use, a few clears
    // and ignored codes; every field carries random bits whatever the code.
    function automatic blfc_pkg::in_item_t random_item(int unsigned taps);
        blfc_pkg::in_item_t it;
        int unsigned        roll;
        int unsigned        span;
        span = (taps == 0 || taps > MAX_TAPS) ? MAX_TAPS : taps;
        it.sample    = random_q();
        it.tap_value = random_q();
        roll = $urandom_range(0, 99);
        if (roll < 50)
            it.tap_index = blfc_pkg::INDEX_W'($urandom_range(0, (span < 128 ? span : 128) - 1));
        else if (roll < 80)
            it.tap_index = blfc_pkg::INDEX_W'($urandom_range(0, span - 1));
        else
            it.tap_index = blfc_pkg::INDEX_W'($urandom_range(0, MAX_TAPS - 1));
        roll = $urandom_range(0, 99);
        if (roll < 72)
            it.operation = blfc_pkg::OP_SAMPLE;
        else if (roll < 95)
            it.operation = blfc_pkg::OP_LOAD;
        else if (roll < 96)
            it.operation = blfc_pkg::OP_CLEAR;
        else
            it.operation = OP_UNUSED;
        return it;
    endfunction

    task automatic push_item(logic [blfc_pkg::OP_W-1:0] op,
                             logic signed [blfc_pkg::SAMPLE_W-1:0] smp,
                             logic [blfc_pkg::INDEX_W-1:0] idx,
                             logic signed [blfc_pkg::SAMPLE_W-1:0] val);
        blfc_pkg::in_item_t it;
        it.operation = op;
        it.sample    = smp;
        it.tap_index = idx;
        it.tap_value = val;
        item_backlog.push_back(it);
    endtask

    // Wait until every item has transferred and every result has come back
    task automatic drain();
        while (item_backlog.size() != 0 || in_valid || filtered_due.size() != 0)
            @(posedge clk);
    endtask

    // Drain, then let any load or clear sweep finish before touching the
    // register; end on a falling edge so backlog pushes sit between edges.
    task automatic wait_idle();
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_tap_count(logic [blfc_pkg::COUNT_W-1:0] v);
        @(posedge clk);
        tap_count_we    <= 1'b1;
        tap_count_wdata <= v;
        @(posedge clk);
        tap_count_we    <= 1'b0;
        tap_setting = v;
        @(negedge clk);
    endtask

    // One random phase: set the register and idling, optionally fire the
    // hold-off, and optionally pause half-way until all results are in.
    task automatic run_phase(logic [blfc_pkg::COUNT_W-1:0] count, int n, int send_pct,
                             int recv_pct, bit hold, bit pause);
        int i;
        wait_idle();
        write_tap_count(count);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        if (hold)
            hold_kick <= ~hold_kick;
        for (i = 0; i < n; i++)
        begin
            if (pause && i == n / 2)
            begin
                drain();
                @(negedge clk);
            end
            item_backlog.push_back(random_item(32'(count)));
        end
    endtask

    initial
    begin
        foreach (coef_mem[i])
            coef_mem[i] = '0;
        foreach (hist_mem[i])
            hist_mem[i] = '0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: bypass after reset with extreme samples, loads at both
        // ends of the tap store, the ignored code with all bits set
        wait_idle();
        push_item(blfc_pkg::OP_SAMPLE, blfc_pkg::SAMPLE_W'(blfc_pkg::Q_MAX), '0, '0);
        push_item(blfc_pkg::OP_SAMPLE, blfc_pkg::SAMPLE_W'(blfc_pkg::Q_MIN), '0, '0);
        push_item(blfc_pkg::OP_SAMPLE, 24'sd0, '1, '1);
        push_item(blfc_pkg::OP_SAMPLE, -24'sd1, '0, '0);
        push_item(blfc_pkg::OP_SAMPLE, 24'sd1, '0, '0);
        push_item(OP_UNUSED, '1, '1, '1);
        push_item(blfc_pkg::OP_LOAD, '0, 12'd0, blfc_pkg::SAMPLE_W'(blfc_pkg::Q_MIN));
        push_item(blfc_pkg::OP_LOAD, '1, 12'd1, blfc_pkg::SAMPLE_W'(blfc_pkg::Q_MAX));
        push_item(blfc_pkg::OP_LOAD, '0, 12'd4095, blfc_pkg::SAMPLE_W'(blfc_pkg::Q_MAX));
        push_item(blfc_pkg::OP_LOAD, '0, 12'd2, 24'sd1);

        // Directed: register at its top value, which acts as the full
        // store; early outputs are silence; clear keeps the taps
        wait_idle();
        write_tap_count('1);
        push_item(blfc_pkg::OP_SAMPLE, blfc_pkg::SAMPLE_W'(blfc_pkg::Q_MIN), '0, '0);
        push_item(blfc_pkg::OP_SAMPLE, blfc_pkg::SAMPLE_W'(blfc_pkg::Q_MAX), '0, '0);
        push_item(blfc_pkg::OP_CLEAR, '1, '1, '1);
        push_item(blfc_pkg::OP_SAMPLE, blfc_pkg::SAMPLE_W'(blfc_pkg::Q_MAX), '0, '0);
        push_item(OP_UNUSED, '0, '0, '0);
        push_item(blfc_pkg::OP_SAMPLE, blfc_pkg::SAMPLE_W'(blfc_pkg::Q_MIN), '0, '0);

        // Random phases across the idling patterns and tap settings
        run_phase(13'd1,    40, 0,  0,  1'b0, 1'b0);
        run_phase(13'd64,   50, 67, 0,  1'b0, 1'b0);
        run_phase(13'd65,   50, 0,  67, 1'b0, 1'b0);
        run_phase(13'd0,   120, 18, 18, 1'b1, 1'b0);
        run_phase(13'd4096, 80, 0,  0,  1'b0, 1'b1);
        run_phase('1,       40, 67, 0,  1'b0, 1'b0);
        run_phase(blfc_pkg::COUNT_W'($urandom_range(2, MAX_TAPS)), 60, 0, 67, 1'b0, 1'b0);
        run_phase(13'd3,    40, 18, 18, 1'b0, 1'b0);
        run_phase(blfc_pkg::COUNT_W'($urandom_range(2, MAX_TAPS)), 84, 0, 0, 1'b0, 1'b0);

        // Drain, then watch a while longer for any stray result
        wait_idle();
        if (fail_count == 0 && filtered_due.size() == 0)
            $display("** block_latency_fir_convolver_core: PASSED **");
        else
            $display("** block_latency_fir_convolver_core: FAILED **");
        $finish;
    end

    // Watchdog: drop the run if it hangs
    initial
    begin
        #(RUN_LIMIT);
        $display("** block_latency_fir_convolver_core: FAILED **");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/blfc_pkg.sv
rtl/core/blfc_ram.sv
rtl/core/blfc_cell.sv
rtl/core/block_latency_fir_convolver_core.sv
tb/tb_block_latency_fir_convolver_core.sv
